>>> sv/lav_pkg.sv
`default_nettype none

package lav_pkg;

    localparam int CoordW   = 32;              // input coordinate width, Q16.16
    localparam int TermW    = 32;              // output term width
    localparam int UnitW    = 30;              // fraction bits of a Q1.30 term
    localparam int BackMagW = CoordW + 1;      // magnitude of eye minus target
    localparam int CrossW   = 2 * CoordW;      // signed cross or dot product
    localparam int CrossMagW = CrossW - 1;     // magnitude of the up cross product
    localparam int SqrtInW  = 2 * UnitW + 2;   // sum of three squares
    localparam int LenW     = SqrtInW / 2;     // vector length, also quotient width
    localparam int NumW     = 2 * UnitW + 1;   // scaled dividend of a unit term
    localparam int NormLat  = 69;              // pipeline depth of lav_norm

    localparam logic [LenW-1:0] One30 = LenW'(1) << UnitW;

    typedef struct packed {
        logic signed [CoordW-1:0] eye_x;
        logic signed [CoordW-1:0] eye_y;
        logic signed [CoordW-1:0] eye_z;
        logic signed [CoordW-1:0] target_x;
        logic signed [CoordW-1:0] target_y;
        logic signed [CoordW-1:0] target_z;
        logic signed [CoordW-1:0] up_x;
        logic signed [CoordW-1:0] up_y;
        logic signed [CoordW-1:0] up_z;
    } t_view_in;

    typedef struct packed {
        logic signed [TermW-1:0] right_x;
        logic signed [TermW-1:0] right_y;
        logic signed [TermW-1:0] right_z;
        logic signed [TermW-1:0] above_x;
        logic signed [TermW-1:0] above_y;
        logic signed [TermW-1:0] above_z;
        logic signed [TermW-1:0] backward_x;
        logic signed [TermW-1:0] backward_y;
        logic signed [TermW-1:0] backward_z;
        logic signed [CoordW-1:0] shift_x;
        logic signed [CoordW-1:0] shift_y;
        logic signed [CoordW-1:0] shift_z;
    } t_view_out;

endpackage

`default_nettype wire

>>> sv/look_at_view_matrix_core.sv
`default_nettype none

// Channel   Ports                        Dir  Handshake
// ------    ---------------------------  ---  ------------------------------------
// view      start, busy, i_view          in   word taken when start && !busy
// matrix    o_valid, o_result            out  word present for one cycle at o_valid
//
// One view enters every cycle; busy is always low.
// Each view makes two passes through a normalize unit (31-stage root and
// 31-stage divider in each pass) on its way to o_valid.
// Reset clears only the valid pipe; in-flight words are dropped.
// Results cannot be held off, and none is needed: the pipe never stalls.
module look_at_view_matrix_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  lav_pkg::t_view_in  i_view,
    output logic               o_valid,
    output lav_pkg::t_view_out o_result
);

    localparam int CW    = lav_pkg::CoordW;
    localparam int TW    = lav_pkg::TermW;
    localparam int BMW   = lav_pkg::BackMagW;
    localparam int XW    = lav_pkg::CrossW;
    localparam int XMW   = lav_pkg::CrossMagW;
    localparam int AccW  = XW + 2;
    localparam int RndW  = AccW - lav_pkg::UnitW;

    localparam int StD   = 1;
    localparam int StB   = StD + lav_pkg::NormLat;
    localparam int StM   = StB + 3;
    localparam int StR   = StM + lav_pkg::NormLat;
    localparam int StX3  = StR + 3;
    localparam int StX4  = StR + 4;
    localparam int StOut = StR + 7;

    localparam logic signed [AccW-1:0] HalfUp = AccW'(1) << (lav_pkg::UnitW - 1);
    localparam logic signed [AccW-1:0] HalfDn = HalfUp - AccW'(1);
    localparam logic signed [RndW-1:0] PosOne = RndW'(1) << lav_pkg::UnitW;
    localparam logic signed [RndW-1:0] NegOne = -PosOne;
    localparam logic signed [RndW-1:0] SatHi  = RndW'(1) << (CW - 1);
    localparam logic signed [RndW-1:0] SatLo  = -SatHi;
    localparam logic [CW-1:0] MinOut = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] MaxOut = {1'b0, {(CW-1){1'b1}}};

    // round a Q2.60 style sum to Q1.30, half away from zero
    function automatic logic signed [RndW-1:0] round_q30(input logic signed [AccW-1:0] x);
        logic signed [AccW-1:0] y;
        y = x + (x[AccW-1] ? HalfDn : HalfUp);
        return y[AccW-1:lav_pkg::UnitW];
    endfunction

    function automatic logic [TW-1:0] clamp_unit(input logic signed [RndW-1:0] r);
        logic [TW-1:0] res;
        if (r > PosOne) begin
            res = TW'(PosOne);
        end else if (r < NegOne) begin
            res = TW'(NegOne);
        end else begin
            res = r[TW-1:0];
        end
        return res;
    endfunction

    function automatic logic [CW-1:0] neg_sat(input logic signed [RndW-1:0] r);
        logic signed [RndW-1:0] nr;
        logic [CW-1:0]          res;
        nr = -r;
        if (r >= SatHi) begin
            res = MinOut;
        end else if (r <= SatLo) begin
            res = MaxOut;
        end else begin
            res = nr[CW-1:0];
        end
        return res;
    endfunction

    assign busy = 1'b0;

    // valid pipe
    logic [StOut:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[StOut-1:0], start & ~busy};
        end
    end

    lav_pkg::t_view_in r_in;

    always_ff @(posedge i_clk) begin
        r_in <= i_view;
    end

    logic [2:0][CW-1:0] eye_0;
    logic [2:0][CW-1:0] tgt_0;
    logic [2:0][CW-1:0] up_0;

    assign eye_0 = {r_in.eye_z, r_in.eye_y, r_in.eye_x};
    assign tgt_0 = {r_in.target_z, r_in.target_y, r_in.target_x};
    assign up_0  = {r_in.up_z, r_in.up_y, r_in.up_x};

    // stage D: eye minus target in sign-magnitude, up prescale
    logic [2:0][BMW-1:0] r_d_mag;
    logic [2:0][BMW-1:0] n_d_mag;
    logic [2:0]          r_d_neg;
    logic [2:0]          n_d_neg;
    logic [2:0][CW-1:0]  r_u;
    logic [2:0][CW-1:0]  n_u;
    logic signed [BMW-1:0] diff;
    logic [CW-1:0]       up_mag;
    logic                up_min;

    always_comb begin
        diff   = '0;
        up_mag = '0;
        up_min = (up_0[0] == MinOut) || (up_0[1] == MinOut) || (up_0[2] == MinOut);
        for (int j = 0; j < 3; j++) begin
            diff       = BMW'($signed(eye_0[j])) - BMW'($signed(tgt_0[j]));
            n_d_neg[j] = diff[BMW-1];
            n_d_mag[j] = diff[BMW-1] ? BMW'(-diff) : BMW'(diff);
            up_mag     = up_0[j][CW-1] ? (CW'(0) - up_0[j]) : up_0[j];
            if (up_min) begin
                up_mag = up_mag >> 1;
                n_u[j] = up_0[j][CW-1] ? (CW'(0) - up_mag) : up_mag;
            end else begin
                n_u[j] = up_0[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_mag <= n_d_mag;
        r_d_neg <= n_d_neg;
        r_u     <= n_u;
    end

    logic [2:0][TW-1:0] back_b;

    lav_norm #(
        .MAG_W (BMW)
    ) u_norm_back (
        .i_clk  (i_clk),
        .i_mag  (r_d_mag),
        .i_neg  (r_d_neg),
        .o_term (back_b)
    );

    logic [2:0][CW-1:0] u_b;

    lav_delay #(
        .WIDTH (3 * CW),
        .DEPTH (StB - StD)
    ) u_dly_up (
        .i_clk (i_clk),
        .i_d   (r_u),
        .o_q   (u_b)
    );

    // stage P: products of up cross backward
    logic signed [XW-1:0] r_pa [3];
    logic signed [XW-1:0] r_pb [3];

    always_ff @(posedge i_clk) begin
        r_pa[0] <= $signed(u_b[1]) * $signed(back_b[2]);
        r_pb[0] <= $signed(u_b[2]) * $signed(back_b[1]);
        r_pa[1] <= $signed(u_b[2]) * $signed(back_b[0]);
        r_pb[1] <= $signed(u_b[0]) * $signed(back_b[2]);
        r_pa[2] <= $signed(u_b[0]) * $signed(back_b[1]);
        r_pb[2] <= $signed(u_b[1]) * $signed(back_b[0]);
    end

    // stage C: differences
    logic signed [XW-1:0] r_cr [3];

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_cr[j] <= r_pa[j] - r_pb[j];
        end
    end

    // stage M: sign-magnitude for the second normalize
    logic [2:0][XMW-1:0] r_m_mag;
    logic [2:0]          r_m_neg;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_m_neg[j] <= r_cr[j][XW-1];
            r_m_mag[j] <= r_cr[j][XW-1] ? XMW'(-r_cr[j]) : XMW'(r_cr[j]);
        end
    end

    logic [2:0][TW-1:0] right_r;

    lav_norm #(
        .MAG_W (XMW)
    ) u_norm_right (
        .i_clk  (i_clk),
        .i_mag  (r_m_mag),
        .i_neg  (r_m_neg),
        .o_term (right_r)
    );

    logic [2:0][TW-1:0] back_r;
    logic [2:0][CW-1:0] eye_r;
    logic [2:0][CW-1:0] eye_a;

    lav_delay #(
        .WIDTH (3 * TW),
        .DEPTH (StR - StB)
    ) u_dly_back (
        .i_clk (i_clk),
        .i_d   (back_b),
        .o_q   (back_r)
    );

    lav_delay #(
        .WIDTH (3 * CW),
        .DEPTH (StR)
    ) u_dly_eye (
        .i_clk (i_clk),
        .i_d   (eye_0),
        .o_q   (eye_r)
    );

    lav_delay #(
        .WIDTH (3 * CW),
        .DEPTH (StX3 - StR)
    ) u_dly_eye_a (
        .i_clk (i_clk),
        .i_d   (eye_r),
        .o_q   (eye_a)
    );

    // stage X1: products for above, right.eye and backward.eye
    logic signed [XW-1:0] r_xa [3];
    logic signed [XW-1:0] r_xb [3];
    logic signed [XW-1:0] r_dr [3];
    logic signed [XW-1:0] r_db [3];

    always_ff @(posedge i_clk) begin
        r_xa[0] <= $signed(back_r[1]) * $signed(right_r[2]);
        r_xb[0] <= $signed(back_r[2]) * $signed(right_r[1]);
        r_xa[1] <= $signed(back_r[2]) * $signed(right_r[0]);
        r_xb[1] <= $signed(back_r[0]) * $signed(right_r[2]);
        r_xa[2] <= $signed(back_r[0]) * $signed(right_r[1]);
        r_xb[2] <= $signed(back_r[1]) * $signed(right_r[0]);
        for (int j = 0; j < 3; j++) begin
            r_dr[j] <= $signed(right_r[j]) * $signed(eye_r[j]);
            r_db[j] <= $signed(back_r[j]) * $signed(eye_r[j]);
        end
    end

    // stage X2: cross differences and dot sums
    logic signed [AccW-1:0] r_ab [3];
    logic signed [AccW-1:0] r_sr;
    logic signed [AccW-1:0] r_sb;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_ab[j] <= AccW'(r_xa[j]) - AccW'(r_xb[j]);
        end
        r_sr <= AccW'(r_dr[0]) + AccW'(r_dr[1]) + AccW'(r_dr[2]);
        r_sb <= AccW'(r_db[0]) + AccW'(r_db[1]) + AccW'(r_db[2]);
    end

    // stage X3: round above to Q1.30 and the eye dot sums to Q16.16
    logic [2:0][TW-1:0]     r_above;
    logic signed [RndW-1:0] r_rr;
    logic signed [RndW-1:0] r_rb;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_above[j] <= clamp_unit(round_q30(r_ab[j]));
        end
        r_rr <= round_q30(r_sr);
        r_rb <= round_q30(r_sb);
    end

    // stage X4: negate and saturate x and z, products for above.eye
    logic [CW-1:0]        r_shx;
    logic [CW-1:0]        r_shz;
    logic signed [XW-1:0] r_da [3];

    always_ff @(posedge i_clk) begin
        r_shx <= neg_sat(r_rr);
        r_shz <= neg_sat(r_rb);
        for (int j = 0; j < 3; j++) begin
            r_da[j] <= $signed(r_above[j]) * $signed(eye_a[j]);
        end
    end

    // stages X5 to X7: above.eye sum, round, negate and saturate
    logic signed [AccW-1:0] r_sa;
    logic signed [RndW-1:0] r_ra;
    logic [CW-1:0]          r_shy;

    always_ff @(posedge i_clk) begin
        r_sa  <= AccW'(r_da[0]) + AccW'(r_da[1]) + AccW'(r_da[2]);
        r_ra  <= round_q30(r_sa);
        r_shy <= neg_sat(r_ra);
    end

    // align everything to the output stage
    logic [2:0][TW-1:0] right_o;
    logic [2:0][TW-1:0] back_o;
    logic [2:0][TW-1:0] above_o;
    logic [CW-1:0]      shx_o;
    logic [CW-1:0]      shz_o;

    lav_delay #(
        .WIDTH (6 * TW),
        .DEPTH (StOut - StR)
    ) u_dly_axes (
        .i_clk (i_clk),
        .i_d   ({right_r, back_r}),
        .o_q   ({right_o, back_o})
    );

    lav_delay #(
        .WIDTH (3 * TW),
        .DEPTH (StOut - StX3)
    ) u_dly_above (
        .i_clk (i_clk),
        .i_d   (r_above),
        .o_q   (above_o)
    );

    lav_delay #(
        .WIDTH (2 * CW),
        .DEPTH (StOut - StX4)
    ) u_dly_shift (
        .i_clk (i_clk),
        .i_d   ({r_shx, r_shz}),
        .o_q   ({shx_o, shz_o})
    );

    assign o_valid             = r_vld[StOut];
    assign o_result.right_x    = right_o[0];
    assign o_result.right_y    = right_o[1];
    assign o_result.right_z    = right_o[2];
    assign o_result.above_x    = above_o[0];
    assign o_result.above_y    = above_o[1];
    assign o_result.above_z    = above_o[2];
    assign o_result.backward_x = back_o[0];
    assign o_result.backward_y = back_o[1];
    assign o_result.backward_z = back_o[2];
    assign o_result.shift_x    = shx_o;
    assign o_result.shift_y    = r_shy;
    assign o_result.shift_z    = shz_o;

`ifndef ASSERT_OFF
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
            o_result.right_x <= 32'sd1073741824 && o_result.right_x >= -32'sd1073741824 &&
            o_result.right_y <= 32'sd1073741824 && o_result.right_y >= -32'sd1073741824 &&
            o_result.right_z <= 32'sd1073741824 && o_result.right_z >= -32'sd1073741824 &&
            o_result.backward_x <= 32'sd1073741824 &&
            o_result.backward_x >= -32'sd1073741824 &&
            o_result.backward_y <= 32'sd1073741824 &&
            o_result.backward_y >= -32'sd1073741824 &&
            o_result.backward_z <= 32'sd1073741824 &&
            o_result.backward_z >= -32'sd1073741824)
        else $error("rotation term outside unit range");

    a_eye_on_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.backward_x == '0 && o_result.backward_y == '0 &&
         o_result.backward_z == '0) |->
            (o_result.right_x == '0 && o_result.right_y == '0 && o_result.right_z == '0 &&
             o_result.shift_z == '0))
        else $error("zero view axis gave nonzero right axis or shift");

    a_up_parallel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.right_x == '0 && o_result.right_y == '0 &&
         o_result.right_z == '0) |->
            (o_result.above_x == '0 && o_result.above_y == '0 && o_result.above_z == '0 &&
             o_result.shift_x == '0 && o_result.shift_y == '0))
        else $error("zero right axis gave nonzero above axis or shift");
`endif

endmodule

`default_nettype wire

>>> sv/lav_delay.sv
`default_nettype none

module lav_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_sr [DEPTH];

    always_ff @(posedge i_clk) begin
        r_sr[0] <= i_d;
        for (int k = 1; k < DEPTH; k++) begin
            r_sr[k] <= r_sr[k-1];
        end
    end

    assign o_q = r_sr[DEPTH-1];

endmodule

`default_nettype wire

>>> sv/lav_isqrt.sv
`default_nettype none

// Digit-by-digit square root, one result bit per stage.
module lav_isqrt (
    input  logic                        i_clk,
    input  logic [lav_pkg::SqrtInW-1:0] i_n,
    output logic [lav_pkg::LenW-1:0]    o_root
);

    localparam int InW   = lav_pkg::SqrtInW;
    localparam int Steps = lav_pkg::LenW;

    logic [InW-1:0] rem_q  [Steps];
    logic [InW-1:0] root_q [Steps+1];

    assign rem_q[0]  = i_n;
    assign root_q[0] = '0;

    for (genvar k = 0; k < Steps; k++) begin : g_step
        localparam logic [InW:0] Bit = (InW+1)'(1) << (InW - 2 - 2 * k);
        logic [InW:0]   trial;
        logic           take;
        logic [InW-1:0] n_root;
        logic [InW-1:0] r_root;

        always_comb begin
            trial = {1'b0, root_q[k]} + Bit;
            take  = ({1'b0, rem_q[k]} >= trial);
            if (take) begin
                n_root = (root_q[k] >> 1) + Bit[InW-1:0];
            end else begin
                n_root = root_q[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            r_root <= n_root;
        end
        assign root_q[k+1] = r_root;

        if (k < Steps - 1) begin : g_rem
            logic [InW-1:0] n_rem;
            logic [InW-1:0] r_rem;
            always_comb begin
                if (take) begin
                    n_rem = rem_q[k] - trial[InW-1:0];
                end else begin
                    n_rem = rem_q[k];
                end
            end
            always_ff @(posedge i_clk) begin
                r_rem <= n_rem;
            end
            assign rem_q[k+1] = r_rem;
        end
    end

    assign o_root = root_q[Steps][Steps-1:0];

endmodule

`default_nettype wire

>>> sv/lav_div.sv
`default_nettype none

// Restoring divider, one quotient bit per stage, most significant first.
module lav_div (
    input  logic                     i_clk,
    input  logic [lav_pkg::NumW-1:0] i_num,
    input  logic [lav_pkg::LenW-1:0] i_den,
    output logic [lav_pkg::LenW-1:0] o_quo
);

    localparam int NW    = lav_pkg::NumW;
    localparam int QW    = lav_pkg::LenW;
    localparam int Steps = QW;

    logic [NW-1:0] rem_q [Steps];
    logic [QW-1:0] den_q [Steps];
    logic [QW-1:0] quo_q [Steps+1];

    assign rem_q[0] = i_num;
    assign den_q[0] = i_den;
    assign quo_q[0] = '0;

    for (genvar k = 0; k < Steps; k++) begin : g_step
        logic [NW-1:0] sub;
        logic          take;
        logic [QW-1:0] n_quo;
        logic [QW-1:0] r_quo;

        always_comb begin
            sub   = NW'(den_q[k]) << (QW - 1 - k);
            take  = (rem_q[k] >= sub);
            n_quo = quo_q[k] | (QW'(take) << (QW - 1 - k));
        end

        always_ff @(posedge i_clk) begin
            r_quo <= n_quo;
        end
        assign quo_q[k+1] = r_quo;

        if (k < Steps - 1) begin : g_rem
            logic [NW-1:0] n_rem;
            logic [NW-1:0] r_rem;
            logic [QW-1:0] r_den;
            always_comb begin
                if (take) begin
                    n_rem = rem_q[k] - sub;
                end else begin
                    n_rem = rem_q[k];
                end
            end
            always_ff @(posedge i_clk) begin
                r_rem <= n_rem;
                r_den <= den_q[k];
            end
            assign rem_q[k+1] = r_rem;
            assign den_q[k+1] = r_den;
        end
    end

    assign o_quo = quo_q[Steps];

endmodule

`default_nettype wire

>>> sv/lav_norm.sv
`default_nettype none

// Unit vector in Q1.30 from three sign-magnitude components.
module lav_norm #(
    parameter int MAG_W = lav_pkg::BackMagW
) (
    input  logic                           i_clk,
    input  logic [2:0][MAG_W-1:0]          i_mag,
    input  logic [2:0]                     i_neg,
    output logic [2:0][lav_pkg::TermW-1:0] o_term
);

    localparam int PosW = $clog2(MAG_W);
    localparam int MW   = lav_pkg::UnitW;
    localparam int SqW  = 2 * MW;
    localparam int InW  = lav_pkg::SqrtInW;
    localparam int LW   = lav_pkg::LenW;
    localparam int NW   = lav_pkg::NumW;
    localparam int TW   = lav_pkg::TermW;
    localparam int SideW = 3 * MW + 4;
    localparam logic [PosW-1:0] TopPos = PosW'(MW - 1);

    // stage A: largest magnitude
    logic [2:0][MAG_W-1:0] r_a_mag;
    logic [2:0]            r_a_neg;
    logic [MAG_W-1:0]      r_a_mx;
    logic [MAG_W-1:0]      n_a_mx;

    always_comb begin
        n_a_mx = i_mag[0];
        if (i_mag[1] > n_a_mx) begin
            n_a_mx = i_mag[1];
        end
        if (i_mag[2] > n_a_mx) begin
            n_a_mx = i_mag[2];
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_mag <= i_mag;
        r_a_neg <= i_neg;
        r_a_mx  <= n_a_mx;
    end

    // stage B: leading one position
    logic [2:0][MAG_W-1:0] r_b_mag;
    logic [2:0]            r_b_neg;
    logic [PosW-1:0]       r_b_pos;
    logic                  r_b_zero;
    logic [PosW-1:0]       n_b_pos;

    always_comb begin
        n_b_pos = '0;
        for (int k = 0; k < MAG_W; k++) begin
            if (r_a_mx[k]) begin
                n_b_pos = PosW'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_mag  <= r_a_mag;
        r_b_neg  <= r_a_neg;
        r_b_pos  <= n_b_pos;
        r_b_zero <= (r_a_mx == '0);
    end

    // stage C: shift so the largest lands in [2^29, 2^30)
    logic [2:0][MW-1:0] r_c_m;
    logic [2:0][MW-1:0] n_c_m;
    logic [2:0]         r_c_neg;
    logic               r_c_zero;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            if (r_b_pos > TopPos) begin
                n_c_m[j] = MW'(r_b_mag[j] >> (r_b_pos - TopPos));
            end else begin
                n_c_m[j] = MW'(r_b_mag[j] << (TopPos - r_b_pos));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_m    <= n_c_m;
        r_c_neg  <= r_b_neg;
        r_c_zero <= r_b_zero;
    end

    // stage D: squares
    logic [2:0][SqW-1:0] r_d_sq;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_d_sq[j] <= SqW'(r_c_m[j]) * SqW'(r_c_m[j]);
        end
    end

    // stage E: sum of squares
    logic [InW-1:0] r_e_n2;

    always_ff @(posedge i_clk) begin
        r_e_n2 <= InW'(r_d_sq[0]) + InW'(r_d_sq[1]) + InW'(r_d_sq[2]);
    end

    logic [LW-1:0] len;

    lav_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_n    (r_e_n2),
        .o_root (len)
    );

    // hold terms and signs until the length is out
    logic [SideW-1:0]   side_d;
    logic [2:0][MW-1:0] dly_m;
    logic [2:0]         dly_neg;
    logic               dly_zero;

    lav_delay #(
        .WIDTH (SideW),
        .DEPTH (LW + 2)
    ) u_dly_side (
        .i_clk (i_clk),
        .i_d   ({r_c_m, r_c_neg, r_c_zero}),
        .o_q   (side_d)
    );

    assign {dly_m, dly_neg, dly_zero} = side_d;

    // stage F: dividends with half the length added for rounding
    logic [2:0][NW-1:0] r_f_num;
    logic [LW-1:0]      r_f_den;
    logic [2:0]         r_f_neg;
    logic               r_f_zero;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_f_num[j] <= NW'({dly_m[j], {MW{1'b0}}}) + NW'(len >> 1);
        end
        r_f_den  <= len;
        r_f_neg  <= dly_neg;
        r_f_zero <= dly_zero;
    end

    logic [2:0][LW-1:0] quo;

    for (genvar j = 0; j < 3; j++) begin : g_lane
        lav_div u_div (
            .i_clk (i_clk),
            .i_num (r_f_num[j]),
            .i_den (r_f_den),
            .o_quo (quo[j])
        );
    end

    logic [3:0] sign_d;
    logic [2:0] g_neg;
    logic       g_zero;

    lav_delay #(
        .WIDTH (4),
        .DEPTH (LW)
    ) u_dly_sign (
        .i_clk (i_clk),
        .i_d   ({r_f_neg, r_f_zero}),
        .o_q   (sign_d)
    );

    assign {g_neg, g_zero} = sign_d;

    // stage G: limit, apply sign, drop zero vectors
    logic [2:0][TW-1:0] r_g_term;
    logic [2:0][TW-1:0] n_g_term;
    logic [LW-1:0]      q_lim;

    always_comb begin
        q_lim = '0;
        for (int j = 0; j < 3; j++) begin
            q_lim = (quo[j] > lav_pkg::One30) ? lav_pkg::One30 : quo[j];
            if (g_zero) begin
                n_g_term[j] = '0;
            end else if (g_neg[j]) begin
                n_g_term[j] = TW'(0) - TW'(q_lim);
            end else begin
                n_g_term[j] = TW'(q_lim);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_term <= n_g_term;
    end

    assign o_term = r_g_term;

endmodule

`default_nettype wire
